// ===== design/rim_pkg.sv =====
package rim_pkg;

  // Datapath widths
  localparam int unsigned RIM_XLEN   = 64;
  localparam int unsigned RIM_LO_W   = 12;
  localparam int unsigned RIM_HI_W   = RIM_XLEN - RIM_LO_W;
  localparam int unsigned RIM_LEVELS = 3;
  localparam int unsigned RIM_LVW    = $clog2(RIM_LEVELS);

  // Descriptor queue between front and back (power of two)
  localparam int unsigned RIM_QDEPTH = 2;
  localparam int unsigned RIM_QPTRW  = $clog2(RIM_QDEPTH);

  // Request kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_SUB  = 2'd2;

  // Encoding constants
  localparam logic [15:0] ENC_C_ADDI  = 16'h0001;
  localparam logic [15:0] ENC_C_SLLI  = 16'h0002;
  localparam logic [15:0] ENC_C_ADDIW = 16'h2001;
  localparam logic [15:0] ENC_C_LI    = 16'h4001;
  localparam logic [15:0] ENC_C_LUI   = 16'h6001;
  localparam logic [15:0] ENC_C_ADD   = 16'h9002;
  localparam logic [6:0]  OP_LUI      = 7'h37;
  localparam logic [6:0]  OP_IMM      = 7'h13;
  localparam logic [6:0]  OP_IMM32    = 7'h1b;
  localparam logic [2:0]  F3_ADD      = 3'b000;
  localparam logic [4:0]  SCRATCH_REG = 5'd6;
  localparam logic [4:0]  SP_REG      = 5'd2;
  localparam logic [RIM_XLEN-1:0] ROUND_HALF = RIM_XLEN'(64'h800);

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_ADD_SMALL,
    MODE_LOAD_ADD
  } rim_mode_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [4:0]          dest_reg;
    logic signed [63:0]  immediate;
  } rim_in_t;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        compressed;
    logic        last;
  } rim_out_t;

  // One classified request: base pair plus shift/add levels, innermost at 0
  typedef struct packed {
    rim_mode_e                       mode;
    logic [4:0]                      rd;
    logic [4:0]                      dest;
    logic [19:0]                     hi20;
    logic [RIM_LO_W-1:0]             lo12;
    logic [RIM_LVW-1:0]              nlev;
    logic [RIM_LEVELS-1:0][5:0]      lev_shamt;
    logic [RIM_LEVELS-1:0][RIM_LO_W-1:0] lev_lo;
  } rim_desc_t;

endpackage

// ===== design/rv64_immediate_materializer_unit.sv =====
// Channel  Dir  Handshake                 Word
// in       in   in_valid_i / in_ready_o   rim_in_t  {kind, dest_reg, immediate}
// out      out  out_valid_o / out_ready_i rim_out_t {instr_word, compressed, last}
//
// Front takes one request at a time. A zero add or unused kind is dropped;
// a small add is queued directly; a load or large add runs a round add, a
// trailing-zero search and an arithmetic shift per shift level (up to 3).
// Back emits one word per cycle unless the output stalls, from a 2-deep request
// queue, up to 9 words; it takes the next request once all words are emitted.
// Reset is asynchronous and clears all control; nothing to sweep.
// Output stalls back up into the queue, then into the front, never drop words.
module rv64_immediate_materializer_unit import rim_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rim_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rim_out_t out_data_o
);

  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  rim_desc_t fq_desc, qb_desc;

  // classify and split into levels
  rim_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .desc_valid_o (fq_valid),
    .desc_ready_i (fq_ready),
    .desc_o       (fq_desc)
  );

  // request queue
  rim_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_desc),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_desc)
  );

  // instruction emitter
  rim_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (qb_valid),
    .desc_ready_o (qb_ready),
    .desc_i       (qb_desc),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== design/rim_front.sv =====
module rim_front import rim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rim_in_t   in_data_i,
  output logic      desc_valid_o,
  input  logic      desc_ready_i,
  output rim_desc_t desc_o
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_CLASS,
    F_LVL_A,
    F_LVL_B,
    F_LVL_C,
    F_PUSH
  } f_state_e;

  f_state_e              state_q;
  logic [1:0]            kind_q;
  logic [4:0]            dest_q;
  logic [RIM_XLEN-1:0]   val_q;
  logic [RIM_HI_W-1:0]   sum_q;
  logic [5:0]            tz_q;
  rim_desc_t             desc_q;

  logic [RIM_XLEN-1:0]   neg_val, eff_val, lvl_sum, next_val;
  logic [31:0]           base_sum;
  logic                  eff_zero, eff_fit12, val_fit32;
  logic [5:0]            tz_d, next_sh;
  logic signed [RIM_XLEN-1:0] hs_ext, hs;
  logic                  hs_fit12, hs_fit20, adj;

  // trailing zeros of the rounded upper part, capped one below its width
  function automatic logic [5:0] ctz_hi(logic [RIM_HI_W-1:0] x);
    logic [5:0] n;
    n = 6'(RIM_HI_W - 1);
    for (int i = RIM_HI_W - 2; i >= 0; i--) begin
      if (x[i]) n = 6'(i);
    end
    return n;
  endfunction

  // classification and level arithmetic
  always_comb begin
    neg_val   = '0 - val_q;
    eff_val   = (kind_q == KIND_SUB) ? neg_val : val_q;
    eff_zero  = (eff_val == '0);
    eff_fit12 = (eff_val[RIM_XLEN-1:11] == '0) || (&eff_val[RIM_XLEN-1:11]);
    val_fit32 = (val_q[RIM_XLEN-1:31] == '0) || (&val_q[RIM_XLEN-1:31]);
    base_sum  = val_q[31:0] + ROUND_HALF[31:0];
    lvl_sum   = val_q + ROUND_HALF;
    tz_d      = ctz_hi(sum_q);
    hs_ext    = {{RIM_LO_W{sum_q[RIM_HI_W-1]}}, sum_q};
    hs        = hs_ext >>> tz_q;
    hs_fit12  = (hs[RIM_XLEN-1:11] == '0) || (&hs[RIM_XLEN-1:11]);
    hs_fit20  = (hs[RIM_XLEN-1:19] == '0) || (&hs[RIM_XLEN-1:19]);
    // fold twelve bits of shift into the base when that keeps it in 32 bits
    adj       = (tz_q != '0) && !hs_fit12 && hs_fit20;
    next_val  = adj ? {hs[RIM_HI_W-1:0], {RIM_LO_W{1'b0}}} : hs;
    next_sh   = adj ? tz_q : tz_q + 6'(RIM_LO_W);
  end

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      kind_q  <= '0;
      dest_q  <= '0;
      val_q   <= '0;
      sum_q   <= '0;
      tz_q    <= '0;
      desc_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= in_data_i.kind;
            dest_q  <= in_data_i.dest_reg;
            val_q   <= in_data_i.immediate;
            state_q <= F_CLASS;
          end
        end
        F_CLASS: begin
          desc_q.dest <= dest_q;
          desc_q.nlev <= '0;
          if (kind_q == KIND_LOAD) begin
            desc_q.mode <= MODE_LOAD;
            desc_q.rd   <= dest_q;
            state_q     <= F_LVL_A;
          end else if ((kind_q == KIND_ADD || kind_q == KIND_SUB) && !eff_zero) begin
            if (eff_fit12) begin
              desc_q.mode <= MODE_ADD_SMALL;
              desc_q.rd   <= dest_q;
              desc_q.hi20 <= '0;
              desc_q.lo12 <= eff_val[RIM_LO_W-1:0];
              state_q     <= F_PUSH;
            end else begin
              desc_q.mode <= MODE_LOAD_ADD;
              desc_q.rd   <= SCRATCH_REG;
              val_q       <= eff_val;
              state_q     <= F_LVL_A;
            end
          end else begin
            state_q <= F_IDLE;
          end
        end
        F_LVL_A: begin
          if (val_fit32) begin
            desc_q.hi20 <= base_sum[31:12];
            desc_q.lo12 <= val_q[RIM_LO_W-1:0];
            state_q     <= F_PUSH;
          end else begin
            sum_q            <= lvl_sum[RIM_XLEN-1:RIM_LO_W];
            desc_q.lev_lo    <= {desc_q.lev_lo[RIM_LEVELS-2:0], val_q[RIM_LO_W-1:0]};
            desc_q.lev_shamt <= {desc_q.lev_shamt[RIM_LEVELS-2:0], 6'd0};
            desc_q.nlev      <= desc_q.nlev + 1'b1;
            state_q          <= F_LVL_B;
          end
        end
        F_LVL_B: begin
          tz_q    <= tz_d;
          state_q <= F_LVL_C;
        end
        F_LVL_C: begin
          val_q               <= next_val;
          desc_q.lev_shamt[0] <= next_sh;
          state_q             <= F_LVL_A;
        end
        F_PUSH: begin
          if (desc_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign desc_valid_o = (state_q == F_PUSH);
  assign desc_o       = desc_q;

endmodule

// ===== design/rim_fifo.sv =====
module rim_fifo import rim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  rim_desc_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output rim_desc_t pop_data_o
);

  rim_desc_t                mem_q [RIM_QDEPTH];
  logic [RIM_QPTRW-1:0]     wptr_q, rptr_q;
  logic [RIM_QPTRW:0]       count_q;
  logic                     push, pop;

  assign push_ready_o = (count_q != (RIM_QPTRW+1)'(RIM_QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== design/rim_back.sv =====
module rim_back import rim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_valid_i,
  output logic      desc_ready_o,
  input  rim_desc_t desc_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rim_out_t  out_data_o
);

  // word slots in program order: base pair, then shift/add per level, then C.ADD
  localparam int unsigned SLOTS     = 3 + 2 * RIM_LEVELS;
  localparam logic [3:0]  SLOT_HI   = 4'd0;
  localparam logic [3:0]  SLOT_LO   = 4'd1;
  localparam logic [3:0]  SLOT_CADD = 4'(SLOTS - 1);

  rim_desc_t          desc_q;
  logic [SLOTS-1:0]   mask_q, mask_new, sel_hot;
  logic               out_valid_q;
  rim_out_t           out_q, word_d;
  logic [3:0]         idx;
  logic               emit, take;
  logic               new_hi_nz, hi_nz, h_fit6, lo_fit6, ll_fit6;
  logic [1:0]         lev_raw;
  logic [RIM_LVW-1:0] lev;
  logic [5:0]         sh;
  logic [RIM_LO_W-1:0] ll;
  logic [15:0]        cw;

  function automatic logic [15:0] cfield(logic [5:0] imm, logic [4:0] r);
    return {3'b000, imm[5], r, imm[4:0], 2'b00};
  endfunction

  // which words the next request produces
  always_comb begin
    new_hi_nz   = (desc_i.hi20 != '0);
    mask_new    = '0;
    mask_new[SLOT_HI] = (desc_i.mode != MODE_ADD_SMALL) && new_hi_nz;
    mask_new[SLOT_LO] = (desc_i.mode == MODE_ADD_SMALL) || (desc_i.lo12 != '0) || !new_hi_nz;
    for (int j = 0; j < RIM_LEVELS; j++) begin
      mask_new[2 + 2*j] = (RIM_LVW'(j) < desc_i.nlev);
      mask_new[3 + 2*j] = (RIM_LVW'(j) < desc_i.nlev) && (desc_i.lev_lo[j] != '0);
    end
    mask_new[SLOT_CADD] = (desc_i.mode == MODE_LOAD_ADD);
  end

  // pick the earliest pending slot
  always_comb begin
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) idx = 4'(i);
    end
    sel_hot = SLOTS'(1) << idx;
  end

  // encode the selected word
  always_comb begin
    hi_nz   = (desc_q.hi20 != '0);
    h_fit6  = (desc_q.hi20[19:5] == '0) || (&desc_q.hi20[19:5]);
    lo_fit6 = (desc_q.lo12[11:5] == '0) || (&desc_q.lo12[11:5]);
    lev_raw = idx[2:1] - 2'd1;
    lev     = (idx[2:1] == 2'd0) ? '0 : RIM_LVW'(lev_raw);
    sh      = desc_q.lev_shamt[lev];
    ll      = desc_q.lev_lo[lev];
    ll_fit6 = (ll[11:5] == '0) || (&ll[11:5]);
    cw      = '0;
    word_d.last       = ((mask_q & ~sel_hot) == '0);
    word_d.compressed = 1'b1;
    word_d.instr_word = '0;
    unique case (idx)
      SLOT_HI: begin
        // C.LUI is reserved or repurposed on x0 and x2
        if (h_fit6 && desc_q.rd != '0 && desc_q.rd != SP_REG) begin
          cw = ENC_C_LUI | cfield(desc_q.hi20[5:0], desc_q.rd);
          word_d.instr_word = {16'h0, cw};
        end else begin
          word_d.compressed = 1'b0;
          word_d.instr_word = {desc_q.hi20, desc_q.rd, OP_LUI};
        end
      end
      SLOT_LO: begin
        if (desc_q.mode == MODE_ADD_SMALL) begin
          if (lo_fit6) begin
            cw = ENC_C_ADDI | cfield(desc_q.lo12[5:0], desc_q.rd);
            word_d.instr_word = {16'h0, cw};
          end else begin
            word_d.compressed = 1'b0;
            word_d.instr_word = {desc_q.lo12, desc_q.rd, F3_ADD, desc_q.rd, OP_IMM};
          end
        end else if (lo_fit6 && (!hi_nz || desc_q.rd != '0)) begin
          // C.ADDIW after a LUI, C.LI on its own
          cw = (hi_nz ? ENC_C_ADDIW : ENC_C_LI) | cfield(desc_q.lo12[5:0], desc_q.rd);
          word_d.instr_word = {16'h0, cw};
        end else begin
          word_d.compressed = 1'b0;
          word_d.instr_word = {desc_q.lo12, (hi_nz ? desc_q.rd : 5'd0), F3_ADD,
                               desc_q.rd, (hi_nz ? OP_IMM32 : OP_IMM)};
        end
      end
      SLOT_CADD: begin
        cw = ENC_C_ADD | {4'h0, desc_q.dest, SCRATCH_REG, 2'b00};
        word_d.instr_word = {16'h0, cw};
      end
      default: begin
        if (!idx[0]) begin
          cw = ENC_C_SLLI | cfield(sh, desc_q.rd);
          word_d.instr_word = {16'h0, cw};
        end else if (ll_fit6) begin
          cw = ENC_C_ADDI | cfield(ll[5:0], desc_q.rd);
          word_d.instr_word = {16'h0, cw};
        end else begin
          word_d.compressed = 1'b0;
          word_d.instr_word = {ll, desc_q.rd, F3_ADD, desc_q.rd, OP_IMM};
        end
      end
    endcase
  end

  assign desc_ready_o = (mask_q == '0);
  assign take         = desc_valid_i && desc_ready_o;
  assign emit         = (mask_q != '0) && (!out_valid_q || out_ready_i);

  // slot tracking and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        mask_q <= mask_new;
      end else if (emit) begin
        mask_q <= mask_q & ~sel_hot;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) desc_q <= desc_i;
    if (emit) out_q  <= word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/rim_checker.sv =====
module rim_checker import rim_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input rim_out_t out_data_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  // compressed words leave the upper half clear
  a_comp_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.compressed |-> out_data_i.instr_word[31:16] == '0)
    else $error("compressed word has upper bits set");

  // length flag agrees with the encoding's length bits
  a_len_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.compressed == (out_data_i.instr_word[1:0] != 2'b11))
    else $error("compressed flag disagrees with encoding");

  // full-size words are only LUI, OP-IMM or OP-IMM-32
  a_full_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.compressed |->
      (out_data_i.instr_word[6:0] == OP_LUI) || (out_data_i.instr_word[6:0] == OP_IMM) ||
      (out_data_i.instr_word[6:0] == OP_IMM32))
    else $error("unexpected full-size opcode");

endmodule

bind rv64_immediate_materializer_unit rim_checker u_rim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// ===== dv/rim_word_checker.sv =====
module rim_word_checker import rim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  rim_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rim_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WORDS  = 9;
  localparam int unsigned MAX_LEVELS = 8;
  localparam logic [4:0]  ZERO_REG   = 5'd0;

  rim_out_t    seq_words[$];       // words of the request being expanded
  rim_out_t    expected_words[$];  // words still owed by the block
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_words.size();

  // x read as two's complement fits in n signed bits
  function automatic bit fits_bits(logic [63:0] x, int unsigned n);
    logic [63:0] half;
    half = 64'd1 << (n - 1);
    return (x + half) < (half << 1);
  endfunction

  function automatic logic [63:0] sign_ext(logic [63:0] x, int unsigned n);
    logic [63:0] m, v;
    if (n >= 64) return x;
    m = 64'd1 << (n - 1);
    v = x & ((m << 1) - 64'd1);
    return (v ^ m) - m;
  endfunction

  // 6-bit immediate plus rd, compressed CI layout
  function automatic logic [31:0] c_field(logic [63:0] imm, logic [4:0] rd);
    return {19'd0, imm[5], rd, imm[4:0], 2'b00};
  endfunction

  function automatic void emit(logic [31:0] w, bit comp);
    rim_out_t o;
    if (seq_words.size() < MAX_WORDS) begin
      o.instr_word = comp ? {16'd0, w[15:0]} : w;
      o.compressed = comp;
      o.last       = 1'b0;
      seq_words.push_back(o);
    end
  endfunction

  // 32-bit base: upper part, then low 12 bits
  function automatic void emit_base(logic [4:0] rd, logic [63:0] val);
    logic [63:0] lo12, hi20;
    lo12 = sign_ext(val, 12);
    hi20 = sign_ext((val + ROUND_HALF) >> 12, 20);
    // C.LUI is reserved on x0 and means something else on sp
    if (hi20 != 0 && fits_bits(hi20, 6) && rd != ZERO_REG && rd != SP_REG)
      emit({16'd0, ENC_C_LUI} | c_field(hi20, rd), 1'b1);
    else if (hi20 != 0)
      emit({hi20[19:0], rd, OP_LUI}, 1'b0);
    if (lo12 != 0 || hi20 == 0) begin
      // C.ADDIW on x0 is reserved; C.LI on x0 is a hint and stays
      if (fits_bits(lo12, 6) && (hi20 == 0 || rd != ZERO_REG))
        emit({16'd0, (hi20 != 0) ? ENC_C_ADDIW : ENC_C_LI} | c_field(lo12, rd), 1'b1);
      else if (hi20 != 0)
        emit({lo12[11:0], rd, F3_ADD, rd, OP_IMM32}, 1'b0);
      else
        emit({lo12[11:0], ZERO_REG, F3_ADD, rd, OP_IMM}, 1'b0);
    end
  endfunction

  // full 64-bit load: peel shift/add levels outermost first, emit innermost first
  function automatic void emit_load(logic [4:0] rd, logic [63:0] val);
    logic [63:0] v, hi, lo12;
    logic [5:0]  lev_shift[MAX_LEVELS];
    logic [63:0] lev_lo[MAX_LEVELS];
    int unsigned nlev, tz, shamt;
    int          i;
    v    = val;
    nlev = 0;
    while (!fits_bits(v, 32) && nlev < MAX_LEVELS) begin
      lo12 = sign_ext(v, 12);
      hi   = (v + ROUND_HALF) >> 12;
      tz   = 0;
      while (tz < 51 && hi[tz] == 1'b0) tz++;
      shamt = tz + 12;
      hi    = sign_ext(hi >> tz, 64 - shamt);
      // prefer a LUI-able inner value over a 12-bit one
      if (shamt > 12 && !fits_bits(hi, 12) && fits_bits(hi << 12, 32)) begin
        shamt = shamt - 12;
        hi    = hi << 12;
      end
      lev_shift[nlev] = 6'(shamt);
      lev_lo[nlev]    = lo12;
      nlev++;
      v = hi;
    end
    emit_base(rd, v);
    for (i = int'(nlev) - 1; i >= 0; i--) begin
      emit({16'd0, ENC_C_SLLI} | {19'd0, lev_shift[i][5], rd, lev_shift[i][4:0], 2'b00},
           1'b1);
      if (lev_lo[i] != 0 && fits_bits(lev_lo[i], 6))
        emit({16'd0, ENC_C_ADDI} | c_field(lev_lo[i], rd), 1'b1);
      else if (lev_lo[i] != 0)
        emit({lev_lo[i][11:0], rd, F3_ADD, rd, OP_IMM}, 1'b0);
    end
  endfunction

  function automatic void emit_add(logic [4:0] rd, logic [63:0] imm);
    if (imm == 0) return;
    if (fits_bits(imm, 6)) begin
      emit({16'd0, ENC_C_ADDI} | c_field(imm, rd), 1'b1);
    end else if (fits_bits(imm, 12)) begin
      emit({imm[11:0], rd, F3_ADD, rd, OP_IMM}, 1'b0);
    end else begin
      // large add goes through the scratch register, even when rd is the scratch
      emit_load(SCRATCH_REG, imm);
      emit({16'd0, ENC_C_ADD} | {20'd0, rd, 7'd0} | {25'd0, SCRATCH_REG, 2'd0}, 1'b1);
    end
  endfunction

  // expand one request into the words the block must produce
  function automatic void expand_request(rim_in_t req);
    seq_words.delete();
    case (req.kind)
      KIND_LOAD: emit_load(req.dest_reg, req.immediate);
      KIND_ADD:  emit_add(req.dest_reg, req.immediate);
      KIND_SUB:  emit_add(req.dest_reg, 64'd0 - req.immediate);
      default: ;
    endcase
    if (seq_words.size() > 0) seq_words[seq_words.size() - 1].last = 1'b1;
    foreach (seq_words[k]) expected_words.push_back(seq_words[k]);
  endfunction

  // watch both channels at the edge
  always @(posedge clk_i or negedge rst_ni) begin
    rim_out_t want;
    if (!rst_ni) begin
      expected_words.delete();
      fails = 0;
    end else begin
      if (in_valid_i && in_ready_i) expand_request(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h (compressed %b last %b)", $time,
                   out_data_i.instr_word, out_data_i.compressed, out_data_i.last);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (out_data_i.instr_word !== want.instr_word) begin
            $display("%0t: instr_word expected %h, got %h", $time,
                     want.instr_word, out_data_i.instr_word);
            fails++;
          end
          if (out_data_i.compressed !== want.compressed) begin
            $display("%0t: compressed expected %b, got %b (word %h)", $time,
                     want.compressed, out_data_i.compressed, want.instr_word);
            fails++;
          end
          if (out_data_i.last !== want.last) begin
            $display("%0t: last expected %b, got %b (word %h)", $time,
                     want.last, out_data_i.last, want.instr_word);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top import rim_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 256;
  localparam int unsigned CALM_FROM    = 216;
  localparam int unsigned HOLD_FROM    = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  rim_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  rim_out_t    out_data;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned cycles;
  int unsigned rand_idx;
  bit          calm;
  bit          hold_done;

  rv64_immediate_materializer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  rim_word_checker word_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic rim_in_t mk(logic [1:0] kind, logic [4:0] rd, logic [63:0] imm);
    rim_in_t r;
    r.kind      = kind;
    r.dest_reg  = rd;
    r.immediate = imm;
    return r;
  endfunction

  // mix of value widths so every expansion depth shows up
  function automatic logic [63:0] pick_immediate();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return 64'(int'($urandom_range(0, 80)) - 40);
      1: return {{52{r[11]}}, r[11:0]};
      2: return {{32{r[31]}}, r[31:0]};
      3: return r;
      4: return $signed(r) >>> $urandom_range(1, 40);
      5: return ({{44{r[19]}}, r[19:0]} << $urandom_range(12, 44))
                + 64'(int'($urandom_range(0, 4)) - 2);
      default: return (64'd1 << $urandom_range(0, 63)) + 64'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 9))
      0: return '0;  // x0
      1: return SP_REG;
      2: return SCRATCH_REG;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  // offer one word, hold until taken, then maybe leave a gap
  task automatic send_word(input rim_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off, none at the end
  initial begin
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && !calm && rand_idx >= HOLD_FROM) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rand_idx = 0;
    calm     = 1'b0;
    rst_n    = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, register special cases, every kind
    send_word(mk(KIND_LOAD, 5'd5,  64'd0));
    send_word(mk(KIND_LOAD, '0,    64'd0));
    send_word(mk(KIND_LOAD, 5'd10, 64'd31));
    send_word(mk(KIND_LOAD, 5'd10, -64'sd33));
    send_word(mk(KIND_LOAD, 5'd11, 64'd2048));
    send_word(mk(KIND_LOAD, SP_REG, 64'h1000));
    send_word(mk(KIND_LOAD, '0,    64'h1000));
    send_word(mk(KIND_LOAD, '0,    64'h1001));
    send_word(mk(KIND_LOAD, 5'd31, 64'h0000_0000_7fff_ffff));
    send_word(mk(KIND_LOAD, 5'd31, 64'hffff_ffff_8000_0000));
    send_word(mk(KIND_LOAD, 5'd12, 64'h0000_0000_8000_0000));
    send_word(mk(KIND_LOAD, 5'd13, 64'h7fff_ffff_ffff_ffff));
    send_word(mk(KIND_LOAD, 5'd14, 64'h8000_0000_0000_0000));
    send_word(mk(KIND_LOAD, 5'd15, 64'h1234_5678_9abc_def0));
    send_word(mk(KIND_LOAD, 5'd16, 64'h0000_0001_0000_0000));
    send_word(mk(KIND_ADD,  5'd1,  64'd0));
    send_word(mk(KIND_ADD,  5'd1,  -64'sd32));
    send_word(mk(KIND_ADD,  '0,    64'd2047));
    send_word(mk(KIND_ADD,  5'd20, -64'sd2048));
    send_word(mk(KIND_ADD,  5'd21, 64'd2048));
    send_word(mk(KIND_ADD,  SCRATCH_REG, 64'h7fff_ffff_ffff_ffff));
    send_word(mk(KIND_SUB,  5'd3,  64'd0));
    send_word(mk(KIND_SUB,  5'd4,  64'h8000_0000_0000_0000));
    send_word(mk(KIND_SUB,  5'd30, -64'sd2048));
    send_word(mk(KIND_SUB,  5'd31, 64'hffff_ffff_ffff_ffff));

    // random part
    while (rand_idx < RANDOM_ITEMS) begin
      calm = (rand_idx >= CALM_FROM);
      send_word(mk(2'($urandom_range(0, 2)), pick_reg(), pick_immediate()));
      rand_idx++;
    end
    in_valid <= 1'b0;

    // drain, then allow for a request still in flight
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
